// ----- rtl/core/rxrc_pkg.sv -----
// ----------------------------------------------------------------------------
// rxrc_pkg
// Shared types and constants of the receive ring consumer.
// ----------------------------------------------------------------------------
package rxrc_pkg;

    // Ring geometry and round budget
    localparam int RING_BYTES   = 32768;
    localparam int FRAME_BUDGET = 64;

    localparam int POS_W    = $clog2(RING_BYTES);
    // Read position plus a legal frame stays below twice the ring size
    localparam int SUM_W    = POS_W + 1;
    localparam int BUDGET_W = 7;
    localparam int WORD_W   = 16;
    localparam int FLEN_W   = 12;
    localparam int ACT_W    = 3;
    localparam int KIND_W   = 2;
    localparam int CFG_IDX_W = 1;

    localparam logic [WORD_W-1:0] EARLY_MARK = 16'hFFF0;
    localparam logic [WORD_W-1:0] PTR_BIAS   = 16'd16;
    localparam logic [FLEN_W-1:0] HDR_BYTES  = 12'd4;

    // Input kinds
    localparam logic [KIND_W-1:0] KIND_START  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_HEADER = 2'd1;
    localparam logic [KIND_W-1:0] KIND_BUSERR = 2'd2;

    // Result actions
    localparam logic [ACT_W-1:0] ACT_DELIVER    = 3'd0;
    localparam logic [ACT_W-1:0] ACT_EARLY      = 3'd1;
    localparam logic [ACT_W-1:0] ACT_BAD_HDR    = 3'd2;
    localparam logic [ACT_W-1:0] ACT_BUDGET_OUT = 3'd3;
    localparam logic [ACT_W-1:0] ACT_ROUND      = 3'd4;
    localparam logic [ACT_W-1:0] ACT_ERR_RESET  = 3'd5;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEN = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN = 1'd1;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [WORD_W-1:0] hdr_status;
        logic [WORD_W-1:0] hdr_length;
    } in_item_t;

    typedef struct packed {
        logic                has_result;
        logic [ACT_W-1:0]    action;
        logic [WORD_W-1:0]   payload_offset;
        logic [FLEN_W-1:0]   payload_length;
        logic [WORD_W-1:0]   pointer_value;
        logic [POS_W-1:0]    read_pos;
        logic [BUDGET_W-1:0] budget_left;
    } eval_t;

endpackage

// ----- rtl/core/rxrc_in_stage.sv -----
// ----------------------------------------------------------------------------
// rxrc_in_stage
// Input register: holds one accepted transaction until the core takes it.
// ----------------------------------------------------------------------------
module rxrc_in_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  rxrc_pkg::in_item_t s_item,
    input  logic               take,
    output logic               item_valid,
    output rxrc_pkg::in_item_t item
);
    import rxrc_pkg::*;

    logic     valid_reg;
    in_item_t item_reg;

    // Refill in the same cycle the held item moves on
    assign s_ready    = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            item_reg <= s_item;
        end
    end

endmodule

// ----- rtl/core/rxrc_eval.sv -----
// ----------------------------------------------------------------------------
// rxrc_eval
// Header check and ring position update for one transaction.
// ----------------------------------------------------------------------------
module rxrc_eval (
    input  rxrc_pkg::in_item_t                 item,
    input  logic [rxrc_pkg::POS_W-1:0]         read_pos,
    input  logic [rxrc_pkg::BUDGET_W-1:0]      budget_left,
    input  logic [rxrc_pkg::FLEN_W-1:0]        min_frame_len,
    input  logic [rxrc_pkg::FLEN_W-1:0]        max_frame_len,
    output rxrc_pkg::eval_t                    res
);
    import rxrc_pkg::*;

    logic [WORD_W:0]     off_full;
    logic [SUM_W-1:0]    step_sum;
    logic [SUM_W-1:0]    aligned;
    logic [SUM_W-1:0]    wrapped;
    logic [FLEN_W-1:0]   len_lo;
    logic                bad_hdr;

    assign len_lo   = item.hdr_length[FLEN_W-1:0];
    assign off_full = (WORD_W+1)'(read_pos) + (WORD_W+1)'(HDR_BYTES);
    // Past the header and frame, rounded up to the next dword
    assign step_sum = SUM_W'(read_pos) + SUM_W'(len_lo) + SUM_W'(HDR_BYTES + 12'd3);
    assign aligned  = {step_sum[SUM_W-1:2], 2'b00};
    assign wrapped  = (aligned >= SUM_W'(RING_BYTES)) ? aligned - SUM_W'(RING_BYTES)
                                                      : aligned;
    assign bad_hdr  = !item.hdr_status[0]
                   || (item.hdr_length < WORD_W'(min_frame_len))
                   || (item.hdr_length > WORD_W'(max_frame_len));

    always_comb begin
        res                = '0;
        res.has_result     = 1'b1;
        res.read_pos       = read_pos;
        res.budget_left    = budget_left;
        case (item.kind)
            KIND_START: begin
                res.action      = ACT_ROUND;
                res.budget_left = BUDGET_W'(FRAME_BUDGET);
            end
            KIND_BUSERR: begin
                res.action   = ACT_ERR_RESET;
                res.read_pos = '0;
            end
            KIND_HEADER: begin
                if (budget_left == '0) begin
                    res.action = ACT_BUDGET_OUT;
                end else if (item.hdr_length == EARLY_MARK) begin
                    // End the round, keep the position
                    res.action      = ACT_EARLY;
                    res.budget_left = '0;
                end else if (bad_hdr) begin
                    res.action      = ACT_BAD_HDR;
                    res.read_pos    = '0;
                    res.budget_left = '0;
                end else begin
                    res.action         = ACT_DELIVER;
                    res.budget_left    = budget_left - BUDGET_W'(1);
                    res.payload_offset = off_full[WORD_W-1:0];
                    res.payload_length = (len_lo >= HDR_BYTES) ? len_lo - HDR_BYTES : '0;
                    res.read_pos       = wrapped[POS_W-1:0];
                end
            end
            default: begin
                res.has_result = 1'b0;
            end
        endcase
        // Pointer register value follows the updated position
        res.pointer_value = WORD_W'(res.read_pos) - PTR_BIAS;
    end

endmodule

// ----- rtl/core/rx_ring_consumer.sv -----
// ----------------------------------------------------------------------------
// rx_ring_consumer
// Receive ring consumer: checks frame headers, tracks the ring read position
// and the per-round frame budget, and reports one result per transaction other than kind 3.
// ----------------------------------------------------------------------------
//  Channel   Direction  Contents
//  s_*       in         kind, hdr_status, hdr_length (valid/ready)
//  m_*       out        action, payload_offset, payload_length, pointer_value
//  cfg_*     in         write of min_frame_len (0) or max_frame_len (1)
//
//  One transaction per cycle sustained while the result is not stalled; an accepted
//  transaction passes the input register, then the result register.
//  The read position and budget update in the cycle the result is loaded,
//  so the next transaction sees them at once.
//  A stalled result holds; the input register still takes one transaction.
//  Kind 3 is consumed without a result. Reset clears position and budget.
// ----------------------------------------------------------------------------
module rx_ring_consumer (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [rxrc_pkg::KIND_W-1:0]        s_kind,
    input  logic [rxrc_pkg::WORD_W-1:0]        s_hdr_status,
    input  logic [rxrc_pkg::WORD_W-1:0]        s_hdr_length,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [rxrc_pkg::ACT_W-1:0]         m_action,
    output logic [rxrc_pkg::WORD_W-1:0]        m_payload_offset,
    output logic [rxrc_pkg::FLEN_W-1:0]        m_payload_length,
    output logic [rxrc_pkg::WORD_W-1:0]        m_pointer_value,
    input  logic                               cfg_wr_en,
    input  logic [rxrc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rxrc_pkg::FLEN_W-1:0]        cfg_wr_data
);
    import rxrc_pkg::*;

    in_item_t            s_item;
    in_item_t            item;
    logic                item_valid;
    logic                take;
    eval_t               res;

    logic [POS_W-1:0]    read_pos_reg;
    logic [BUDGET_W-1:0] budget_reg;
    logic [FLEN_W-1:0]   min_len_reg;
    logic [FLEN_W-1:0]   max_len_reg;

    logic                m_valid_reg;
    logic [ACT_W-1:0]    action_reg;
    logic [WORD_W-1:0]   offset_reg;
    logic [FLEN_W-1:0]   length_reg;
    logic [WORD_W-1:0]   pointer_reg;

    assign s_item.kind       = s_kind;
    assign s_item.hdr_status = s_hdr_status;
    assign s_item.hdr_length = s_hdr_length;

    assign take = item_valid && (!m_valid_reg || m_ready);

    rxrc_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    rxrc_eval u_eval (
        .item          (item),
        .read_pos      (read_pos_reg),
        .budget_left   (budget_reg),
        .min_frame_len (min_len_reg),
        .max_frame_len (max_len_reg),
        .res           (res)
    );

    // Ring state and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            read_pos_reg <= '0;
            budget_reg   <= '0;
            min_len_reg  <= 12'd18;
            max_len_reg  <= 12'd1518;
        end else begin
            if (take) begin
                read_pos_reg <= res.read_pos;
                budget_reg   <= res.budget_left;
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_MIN_LEN: min_len_reg <= cfg_wr_data;
                    CFG_MAX_LEN: max_len_reg <= cfg_wr_data;
                    default:     ;
                endcase
            end
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (take && res.has_result) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (take && res.has_result) begin
            action_reg  <= res.action;
            offset_reg  <= res.payload_offset;
            length_reg  <= res.payload_length;
            pointer_reg <= res.pointer_value;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_action         = action_reg;
    assign m_payload_offset = offset_reg;
    assign m_payload_length = length_reg;
    assign m_pointer_value  = pointer_reg;

endmodule
